### rtl/scm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scm_pkg
// Shared types and constants of the serial motor command parser.
// ----------------------------------------------------------------------------
package scm_pkg;

	localparam int unsigned MAX_LINE_CHARS_DEF = 127;
	localparam int unsigned CMD_W              = 16;
	localparam logic [15:0] TIMEOUT_RESET      = 16'd100;

	// Reply codes, also used as the command held while a line is parsed.
	typedef enum logic [2:0] {
		CMD_NONE  = 3'd0,
		CMD_STOP  = 3'd1,
		CMD_FWD   = 3'd2,
		CMD_BACK  = 3'd3,
		CMD_LEFT  = 3'd4,
		CMD_RIGHT = 3'd5,
		CMD_V     = 3'd6,
		CMD_ERR   = 3'd7
	} cmd_t;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_VT    = 8'h0B;
	localparam logic [7:0] CH_FF    = 8'h0C;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_AT    = 8'h40;
	localparam logic [7:0] CH_UP_B  = 8'h42;
	localparam logic [7:0] CH_UP_F  = 8'h46;
	localparam logic [7:0] CH_UP_L  = 8'h4C;
	localparam logic [7:0] CH_UP_R  = 8'h52;
	localparam logic [7:0] CH_UP_S  = 8'h53;
	localparam logic [7:0] CH_UP_V  = 8'h56;
	localparam logic [7:0] CH_LO_S  = 8'h73;

	// Letters of the spelled-out stop word.
	function automatic logic [7:0] stop_char(input logic [1:0] idx);
		case (idx)
			2'd0:    stop_char = 8'h73;
			2'd1:    stop_char = 8'h74;
			2'd2:    stop_char = 8'h6F;
			default: stop_char = 8'h70;
		endcase
	endfunction

	// What one parser step reports to the rest of the block.
	typedef struct packed {
		logic             line_end;
		cmd_t             reply;
		logic [CMD_W-1:0] left_cmd;
		logic [CMD_W-1:0] right_cmd;
	} step_res_t;

endpackage

### rtl/scm_line_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scm_line_parser
// Per-character line parser that holds the line state and the drive commands.
// ----------------------------------------------------------------------------
module scm_line_parser #(
	parameter int unsigned MAX_LINE_CHARS = scm_pkg::MAX_LINE_CHARS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step_en,
	input  logic               is_tick,
	input  logic [7:0]         rx_byte,
	output scm_pkg::step_res_t res
);

	localparam int unsigned LEN_W = $clog2(MAX_LINE_CHARS + 1);

	typedef enum logic [3:0] {
		PH_LEAD      = 4'd0,
		PH_AFTER_AT  = 4'd1,
		PH_STOPMATCH = 4'd2,
		PH_WS        = 4'd3,
		PH_SIGN      = 4'd4,
		PH_DIGITS    = 4'd5,
		PH_WS2       = 4'd6,
		PH_SIGN2     = 4'd7,
		PH_DIGITS2   = 4'd8,
		PH_DONE      = 4'd9,
		PH_RESOLVED  = 4'd10
	} phase_t;

	typedef struct packed {
		phase_t        phase;
		scm_pkg::cmd_t letter;
		logic [2:0]    stop_cnt;
		logic          neg;
		logic [15:0]   mag;
		logic [15:0]   first;
	} line_st_t;

	localparam line_st_t LINE_CLEAR = '{
		phase: PH_LEAD, letter: scm_pkg::CMD_NONE, stop_cnt: 3'd0,
		neg: 1'b0, mag: 16'd0, first: 16'd0
	};

	line_st_t         st_q;
	logic [LEN_W-1:0] len_q;
	logic [15:0]      left_q;
	logic [15:0]      right_q;

	line_st_t         st_nx;
	logic [LEN_W-1:0] len_nx;

	function automatic logic is_ws(input logic [7:0] c);
		is_ws = (c == scm_pkg::CH_SPACE) || (c == scm_pkg::CH_TAB) ||
			(c == scm_pkg::CH_VT) || (c == scm_pkg::CH_FF);
	endfunction

	function automatic line_st_t first_char(input line_st_t s, input logic [7:0] c);
		line_st_t r;
		r       = s;
		r.phase = PH_WS;
		r.neg   = 1'b0;
		r.mag   = 16'd0;
		case (c)
			scm_pkg::CH_UP_S: begin
				r.letter = scm_pkg::CMD_STOP;
				r.phase  = PH_DONE;
			end
			scm_pkg::CH_LO_S: begin
				r.letter   = scm_pkg::CMD_ERR;
				r.stop_cnt = 3'd1;
				r.phase    = PH_STOPMATCH;
			end
			scm_pkg::CH_UP_F: r.letter = scm_pkg::CMD_FWD;
			scm_pkg::CH_UP_B: r.letter = scm_pkg::CMD_BACK;
			scm_pkg::CH_UP_L: r.letter = scm_pkg::CMD_LEFT;
			scm_pkg::CH_UP_R: r.letter = scm_pkg::CMD_RIGHT;
			scm_pkg::CH_UP_V: r.letter = scm_pkg::CMD_V;
			default: begin
				r.letter = scm_pkg::CMD_ERR;
				r.phase  = PH_DONE;
			end
		endcase
		return r;
	endfunction

	// One character of a number field, following atoi with saturation.
	function automatic line_st_t num_step(input line_st_t s, input logic [7:0] c);
		line_st_t    r;
		logic        second;
		logic        sub0;
		logic        sub2;
		logic        digit;
		logic [19:0] prod;
		logic [19:0] acc;
		r      = s;
		second = (s.phase == PH_WS2) || (s.phase == PH_SIGN2) || (s.phase == PH_DIGITS2);
		sub0   = (s.phase == PH_WS) || (s.phase == PH_WS2);
		sub2   = (s.phase == PH_DIGITS) || (s.phase == PH_DIGITS2);
		digit  = (c >= scm_pkg::CH_ZERO) && (c <= scm_pkg::CH_NINE);
		prod   = sub2 ? ({1'b0, s.mag, 3'b000} + {3'b000, s.mag, 1'b0}) : 20'd0;
		acc    = prod + {16'd0, 4'(c - scm_pkg::CH_ZERO)};
		if (sub0 && is_ws(c)) begin
			r = s;
		end else if (sub0 && ((c == scm_pkg::CH_PLUS) || (c == scm_pkg::CH_MINUS))) begin
			r.neg   = (c == scm_pkg::CH_MINUS);
			r.phase = second ? PH_SIGN2 : PH_SIGN;
		end else if (digit) begin
			r.mag   = (acc[19:16] != 4'd0) ? 16'hFFFF : acc[15:0];
			r.phase = second ? PH_DIGITS2 : PH_DIGITS;
		end else if (sub2) begin
			if ((s.letter == scm_pkg::CMD_V) && !second) begin
				// The first V value ends here; a blank or sign in the same character opens the second one, else the text ends.
				r.first = s.neg ? 16'(16'd0 - s.mag) : s.mag;
				r.neg   = 1'b0;
				r.mag   = 16'd0;
				r.phase = PH_WS2;
				if (is_ws(c)) begin
					r.phase = PH_WS2;
				end else if ((c == scm_pkg::CH_PLUS) || (c == scm_pkg::CH_MINUS)) begin
					r.neg   = (c == scm_pkg::CH_MINUS);
					r.phase = PH_SIGN2;
				end else begin
					r.phase = PH_DONE;
				end
			end else begin
				r.phase = PH_DONE;
			end
		end else begin
			if ((s.letter == scm_pkg::CMD_V) && !second) begin
				r.first = 16'd0;
			end
			r.neg   = 1'b0;
			r.mag   = 16'd0;
			r.phase = PH_DONE;
		end
		return r;
	endfunction

	function automatic line_st_t take_char(input line_st_t s, input logic [7:0] c);
		line_st_t r;
		r = s;
		case (s.phase)
			PH_LEAD: begin
				if (c == scm_pkg::CH_AT) begin
					r.phase = PH_AFTER_AT;
				end else if (c != scm_pkg::CH_SPACE) begin
					r = first_char(s, c);
				end
			end
			PH_AFTER_AT: r = first_char(s, c);
			PH_STOPMATCH: begin
				if ((s.stop_cnt < 3'd4) && (c == scm_pkg::stop_char(s.stop_cnt[1:0]))) begin
					r.stop_cnt = 3'(s.stop_cnt + 3'd1);
					if (s.stop_cnt == 3'd3) begin
						r.letter = scm_pkg::CMD_STOP;
						r.phase  = PH_DONE;
					end
				end else begin
					r.letter = scm_pkg::CMD_ERR;
					r.phase  = PH_DONE;
				end
			end
			PH_WS, PH_SIGN, PH_DIGITS, PH_WS2, PH_SIGN2, PH_DIGITS2: r = num_step(s, c);
			default: r = s;
		endcase
		return r;
	endfunction

	// End of text: the left value lands in first, the right value in mag.
	function automatic line_st_t resolve(input line_st_t s);
		line_st_t    r;
		logic [15:0] v;
		logic [15:0] nv;
		logic [15:0] half;
		logic [15:0] l;
		logic [15:0] rt;
		r    = s;
		v    = s.neg ? 16'(16'd0 - s.mag) : s.mag;
		nv   = s.neg ? s.mag : 16'(16'd0 - s.mag);
		half = s.neg ? 16'(16'd0 - (s.mag >> 1)) : (s.mag >> 1);
		case (s.letter)
			scm_pkg::CMD_FWD: begin
				l  = v;
				rt = v;
			end
			scm_pkg::CMD_BACK: begin
				l  = nv;
				rt = nv;
			end
			scm_pkg::CMD_LEFT: begin
				l  = half;
				rt = v;
			end
			scm_pkg::CMD_RIGHT: begin
				l  = v;
				rt = half;
			end
			scm_pkg::CMD_V: begin
				if ((s.phase == PH_WS) || (s.phase == PH_SIGN) || (s.phase == PH_DIGITS)) begin
					l  = v;
					rt = 16'd0;
				end else begin
					l  = s.first;
					rt = v;
				end
			end
			default: begin
				l  = 16'd0;
				rt = 16'd0;
			end
		endcase
		r.first = l;
		r.mag   = rt;
		r.neg   = 1'b0;
		r.phase = PH_RESOLVED;
		return r;
	endfunction

	always_comb begin
		line_st_t fin;
		fin           = (st_q.phase != PH_RESOLVED) ? resolve(st_q) : st_q;
		st_nx         = st_q;
		len_nx        = len_q;
		res.line_end  = 1'b0;
		res.reply     = scm_pkg::CMD_NONE;
		res.left_cmd  = left_q;
		res.right_cmd = right_q;
		if (!is_tick) begin
			if ((rx_byte == scm_pkg::CH_CR) || (rx_byte == scm_pkg::CH_LF)) begin
				if (len_q != '0) begin
					res.line_end = 1'b1;
					res.reply    = fin.letter;
					if ((fin.letter != scm_pkg::CMD_NONE) && (fin.letter != scm_pkg::CMD_ERR)) begin
						res.left_cmd  = fin.first;
						res.right_cmd = fin.mag;
					end
					st_nx  = LINE_CLEAR;
					len_nx = '0;
				end
			end else if (len_q < LEN_W'(MAX_LINE_CHARS)) begin
				len_nx = LEN_W'(len_q + 1'b1);
				// A zero byte closes the text; later bytes still count toward the length.
				st_nx  = (rx_byte == scm_pkg::CH_NUL) ? fin : take_char(st_q, rx_byte);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= LINE_CLEAR;
			len_q   <= '0;
			left_q  <= 16'd0;
			right_q <= 16'd0;
		end else if (step_en) begin
			st_q    <= st_nx;
			len_q   <= len_nx;
			left_q  <= res.left_cmd;
			right_q <= res.right_cmd;
		end
	end

endmodule

### rtl/scm_failsafe.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scm_failsafe
// Idle tick counter and timeout register that decide when the drive stops.
// ----------------------------------------------------------------------------
module scm_failsafe (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	input  logic        step_en,
	input  logic        is_tick,
	input  logic        line_end,
	output logic        stopped
);

	logic [15:0] timeout_q;
	logic [15:0] idle_q;
	logic [15:0] idle_nx;

	always_comb begin
		idle_nx = idle_q;
		if (is_tick) begin
			if (idle_q != 16'hFFFF) begin
				idle_nx = 16'(idle_q + 16'd1);
			end
		end else if (line_end) begin
			idle_nx = 16'd0;
		end
		stopped = (idle_nx >= timeout_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= scm_pkg::TIMEOUT_RESET;
			idle_q    <= 16'd0;
		end else begin
			if (cfg_we) begin
				timeout_q <= cfg_wdata;
			end
			if (step_en) begin
				idle_q <= idle_nx;
			end
		end
	end

endmodule

### rtl/serial_motor_command_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_motor_command_parser
// Line parser for serial motor commands with a failsafe stop on idle ticks.
// ----------------------------------------------------------------------------
// Each input transfer carries either one received character (tuser low) or one
// 10 ms tick (tuser high). Every input transfer yields exactly one output
// transfer with the drive commands in force after it, the failsafe flag and a
// reply code that is nonzero only on the character that ends a non-empty line.
// The item sits in the input register, is parsed by the logic behind it and
// lands in the output register, one item per cycle sustained while the
// receiver keeps accepting.
// The input side stays ready while the output register is empty or drained in
// the same cycle; a stalled receiver fills both registers and then backs up the
// sender without losing or repeating an item.
// Reset clears the line state, both drive commands and the idle count, and sets
// the timeout to 100 ticks. The user writes the timeout register through cfg_we
// and cfg_wdata while no item is in flight; the block does not enforce this.
// ----------------------------------------------------------------------------
module serial_motor_command_parser #(
	parameter int unsigned MAX_LINE_CHARS = scm_pkg::MAX_LINE_CHARS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // rx_byte
	input  logic        s_axis_tuser,   // req_type
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// drive_left [15:0], drive_right [31:16], motor_stopped [32], reply_code [35:33], zero
	output logic [39:0] m_axis_tdata
);

	logic               in_valid_s1;
	logic               in_tick_s1;
	logic [7:0]         in_byte_s1;
	logic               out_valid_s2;
	logic [39:0]        out_data_s2;
	logic               advance;
	logic               stopped;
	scm_pkg::step_res_t res;
	logic [15:0]        drive_l;
	logic [15:0]        drive_r;

	assign advance       = in_valid_s1 && (!out_valid_s2 || m_axis_tready);
	assign s_axis_tready = !in_valid_s1 || advance;

	scm_line_parser #(
		.MAX_LINE_CHARS(MAX_LINE_CHARS)
	) u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (advance),
		.is_tick (in_tick_s1),
		.rx_byte (in_byte_s1),
		.res     (res)
	);

	scm_failsafe u_failsafe (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.step_en   (advance),
		.is_tick   (in_tick_s1),
		.line_end  (res.line_end),
		.stopped   (stopped)
	);

	assign drive_l = stopped ? 16'd0 : res.left_cmd;
	assign drive_r = stopped ? 16'd0 : res.right_cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1  <= 1'b0;
			out_valid_s2 <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				in_valid_s1 <= 1'b1;
			end else if (advance) begin
				in_valid_s1 <= 1'b0;
			end
			if (advance) begin
				out_valid_s2 <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			in_tick_s1 <= s_axis_tuser;
			in_byte_s1 <= s_axis_tdata;
		end
		if (advance) begin
			out_data_s2 <= {4'd0, 3'(res.reply), stopped, drive_r, drive_l};
		end
	end

	assign m_axis_tvalid = out_valid_s2;
	assign m_axis_tdata  = out_data_s2;

endmodule
